/* hdl/scmp_pkg.sv */
// ----------------------------------------------------------------------------
// scmp_pkg
// Shared types and codes for the serial-commanded motor PWM core.
// ----------------------------------------------------------------------------
`default_nettype none

package scmp_pkg;

   // item kinds on the request tuser
   localparam logic [1:0] KIND_LEFT_TICK  = 2'd0;
   localparam logic [1:0] KIND_RIGHT_TICK = 2'd1;
   localparam logic [1:0] KIND_RX_BYTE    = 2'd2;

   // command bytes
   localparam logic [7:0] BYTE_STOP       = 8'h00;
   localparam logic [7:0] BYTE_FORWARD    = 8'h01;
   localparam logic [7:0] BYTE_BACK       = 8'h02;
   localparam logic [7:0] BYTE_LEFT       = 8'h03;
   localparam logic [7:0] BYTE_RIGHT      = 8'h04;
   localparam logic [7:0] BYTE_SPEED_UP   = 8'h05;
   localparam logic [7:0] BYTE_SPEED_DOWN = 8'h06;
   localparam logic [7:0] BYTE_SPEED_DEF  = 8'h07;
   localparam logic [7:0] BYTE_SPEED_FULL = 8'h08;

   // bridge pin patterns: bit0 in1 .. bit3 in4
   localparam logic [3:0] PINS_STOP    = 4'h0;
   localparam logic [3:0] PINS_FORWARD = 4'h5;
   localparam logic [3:0] PINS_BACK    = 4'hA;
   localparam logic [3:0] PINS_LEFT    = 4'h6;
   localparam logic [3:0] PINS_RIGHT   = 4'h9;

   // register indexes
   localparam logic [1:0] CSR_PWM_PERIOD   = 2'd0;
   localparam logic [1:0] CSR_DUTY_DEFAULT = 2'd1;
   localparam logic [1:0] CSR_DUTY_FULL    = 2'd2;
   localparam logic [1:0] CSR_DUTY_LIMIT   = 2'd3;

   // register reset values
   localparam logic [7:0] RST_PWM_PERIOD   = 8'd20;
   localparam logic [7:0] RST_DUTY_DEFAULT = 8'd5;
   localparam logic [7:0] RST_DUTY_FULL    = 8'd20;
   localparam logic [7:0] RST_DUTY_LIMIT   = 8'd20;

   localparam logic [7:0] DUTY_MAX = 8'hFF;

   localparam int RSP_DATA_W = 24;

   typedef struct packed {
      logic [7:0] pwm_period;
      logic [7:0] duty_default;
      logic [7:0] duty_full;
      logic [7:0] duty_limit;
   } cfg_type;

endpackage

`default_nettype wire

/* hdl/scmp_csr.sv */
// ----------------------------------------------------------------------------
// scmp_csr
// Configuration register file, written through the csr channel.
// ----------------------------------------------------------------------------
`default_nettype none

module scmp_csr (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_valid,
   output      logic              csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [7:0]        csr_data,
   output      scmp_pkg::cfg_type cfg
);

   scmp_pkg::cfg_type cfg_ff;
   scmp_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            scmp_pkg::CSR_PWM_PERIOD:   cfg_in.pwm_period   = csr_data;
            scmp_pkg::CSR_DUTY_DEFAULT: cfg_in.duty_default = csr_data;
            scmp_pkg::CSR_DUTY_FULL:    cfg_in.duty_full    = csr_data;
            scmp_pkg::CSR_DUTY_LIMIT:   cfg_in.duty_limit   = csr_data;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pwm_period   <= scmp_pkg::RST_PWM_PERIOD;
         cfg_ff.duty_default <= scmp_pkg::RST_DUTY_DEFAULT;
         cfg_ff.duty_full    <= scmp_pkg::RST_DUTY_FULL;
         cfg_ff.duty_limit   <= scmp_pkg::RST_DUTY_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/scmp_cmd.sv */
// ----------------------------------------------------------------------------
// scmp_cmd
// Command byte decoder: holds the bridge pins and the shared duty.
// ----------------------------------------------------------------------------
`default_nettype none

module scmp_cmd (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              byte_take,   // accepted item is a received byte
   input  wire logic [7:0]        rx_byte,
   input  wire scmp_pkg::cfg_type cfg,
   output      logic [3:0]        pins_in,
   output      logic [7:0]        duty_ff,
   output      logic [7:0]        duty_in
);

   logic [3:0] pins_ff;

   always_comb begin
      pins_in = pins_ff;
      duty_in = duty_ff;
      if (byte_take) begin
         unique case (rx_byte)
            scmp_pkg::BYTE_STOP:    pins_in = scmp_pkg::PINS_STOP;
            scmp_pkg::BYTE_FORWARD: pins_in = scmp_pkg::PINS_FORWARD;
            scmp_pkg::BYTE_BACK:    pins_in = scmp_pkg::PINS_BACK;
            scmp_pkg::BYTE_LEFT:    pins_in = scmp_pkg::PINS_LEFT;
            scmp_pkg::BYTE_RIGHT:   pins_in = scmp_pkg::PINS_RIGHT;
            scmp_pkg::BYTE_SPEED_UP: begin
               // may reach limit+1, never wraps past the top
               if ((duty_ff <= cfg.duty_limit) && (duty_ff != scmp_pkg::DUTY_MAX))
                  duty_in = duty_ff + 8'd1;
            end
            scmp_pkg::BYTE_SPEED_DOWN: begin
               if (duty_ff != 8'd0)
                  duty_in = duty_ff - 8'd1;
            end
            scmp_pkg::BYTE_SPEED_DEF:  duty_in = cfg.duty_default;
            scmp_pkg::BYTE_SPEED_FULL: duty_in = cfg.duty_full;
            default: begin
               pins_in = pins_ff;   // echo only
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pins_ff <= scmp_pkg::PINS_STOP;
         duty_ff <= scmp_pkg::RST_DUTY_DEFAULT;
      end else begin
         pins_ff <= pins_in;
         duty_ff <= duty_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/scmp_pwm.sv */
// ----------------------------------------------------------------------------
// scmp_pwm
// One side's tick counter and PWM level.
// ----------------------------------------------------------------------------
`default_nettype none

module scmp_pwm (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       tick,
   input  wire logic [7:0] pwm_period,
   input  wire logic [7:0] duty,
   output      logic       level_in
);

   logic [7:0] count_ff;
   logic [7:0] count_in;
   logic       level_ff;
   logic [8:0] count_inc;

   assign count_inc = {1'b0, count_ff} + 9'd1;

   always_comb begin
      count_in = count_ff;
      level_in = level_ff;
      if (tick) begin
         // wraps at the period, also when the period dropped below the count
         if (count_inc >= {1'b0, pwm_period})
            count_in = 8'd0;
         else
            count_in = count_inc[7:0];
         level_in = (count_in <= duty);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 8'd0;
         level_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         level_ff <= level_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/serial_command_motor_pwm_core.sv */
// ----------------------------------------------------------------------------
// serial_command_motor_pwm_core
// Results: a result appears on rsp in the cycle after its request transfer.
// Throughput: one item per cycle; the single result register is refilled
// in the cycle it is taken, so req_tready only drops while rsp stalls.
// Reset: synchronous; registers return to their defaults, pins stopped,
// counters and levels cleared, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_command_motor_pwm_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // request: tuser = cmd[1:0]; tdata = rx_byte[7:0]
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,
   input  wire logic [1:0]  req_tuser,
   // result: tuser = echo_valid[0]
   // tdata = echo_byte[7:0], motor_pins[11:8], pwm_left[12], pwm_right[13],
   //         duty_now[21:14], zero[23:22]
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [23:0] rsp_tdata,
   output      logic [0:0]  rsp_tuser,
   // configuration write
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_data
);

   scmp_pkg::cfg_type cfg;

   logic       req_xfer;
   logic       byte_take;
   logic       left_tick;
   logic       right_tick;
   logic [3:0] pins_in;
   logic [7:0] duty_ff;
   logic [7:0] duty_in;
   logic       left_level_in;
   logic       right_level_in;

   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   logic [scmp_pkg::RSP_DATA_W-1:0]     rsp_data_ff;
   logic [scmp_pkg::RSP_DATA_W-1:0]     rsp_data_in;
   logic                                rsp_echo_ff;
   logic                                rsp_echo_in;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;
   assign byte_take  = req_xfer && (req_tuser == scmp_pkg::KIND_RX_BYTE);
   assign left_tick  = req_xfer && (req_tuser == scmp_pkg::KIND_LEFT_TICK);
   assign right_tick = req_xfer && (req_tuser == scmp_pkg::KIND_RIGHT_TICK);

   scmp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   scmp_cmd u_cmd (
      .clock     (clock),
      .reset     (reset),
      .byte_take (byte_take),
      .rx_byte   (req_tdata),
      .cfg       (cfg),
      .pins_in   (pins_in),
      .duty_ff   (duty_ff),
      .duty_in   (duty_in)
   );

   scmp_pwm u_pwm_left (
      .clock      (clock),
      .reset      (reset),
      .tick       (left_tick),
      .pwm_period (cfg.pwm_period),
      .duty       (duty_ff),
      .level_in   (left_level_in)
   );

   scmp_pwm u_pwm_right (
      .clock      (clock),
      .reset      (reset),
      .tick       (right_tick),
      .pwm_period (cfg.pwm_period),
      .duty       (duty_ff),
      .level_in   (right_level_in)
   );

   // result register; tick and unused kinds carry a zero echo byte
   always_comb begin
      rsp_echo_in  = byte_take;
      rsp_data_in  = {2'b00, duty_in, right_level_in, left_level_in, pins_in,
                      (byte_take ? req_tdata : 8'd0)};
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (req_xfer)
         rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_xfer) begin
         rsp_data_ff <= rsp_data_in;
         rsp_echo_ff <= rsp_echo_in;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_echo_ff;

endmodule

`default_nettype wire

/* hdl/scmp_checker.sv */
// ----------------------------------------------------------------------------
// scmp_checker
// Port-level checks for the motor PWM core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module scmp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [7:0]  req_tdata,
   input wire logic [1:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic [0:0]  rsp_tuser
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   a_req_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> rsp_tvalid)
      else $error("request transfer produced no result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
                                       && $stable(rsp_tuser)))
      else $error("stalled result changed");

   a_echo_byte: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == scmp_pkg::KIND_RX_BYTE))
      |=> (rsp_tuser[0] && (rsp_tdata[7:0] == $past(req_tdata))))
      else $error("received byte not echoed");

   a_no_echo: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser != scmp_pkg::KIND_RX_BYTE))
      |=> (!rsp_tuser[0] && (rsp_tdata[7:0] == 8'd0)))
      else $error("echo flagged for a non-byte item");

endmodule

bind serial_command_motor_pwm_core scmp_checker u_scmp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

/* tb/tb_serial_command_motor_pwm_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_serial_command_motor_pwm_core
// Self-checking bench for the serial-commanded motor PWM core. Ticks and
// command bytes go in on req, and each one is run through a local model of
// the pins, shared duty and per-side PWM counters. Every rsp transfer is
// compared field by field against the oldest predicted status. Settings are
// reloaded between phases, both sides idle at random, and one phase holds
// rsp off long enough to back up the input.
// ----------------------------------------------------------------------------

module tb_serial_command_motor_pwm_core;

   // cmd code with no meaning; the core must still answer it
   localparam logic [1:0] KIND_UNUSED  = 2'd3;
   localparam int         DRAIN_CYCLES = 4;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;

   serial_command_motor_pwm_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   typedef struct packed {
      logic       echo_valid;
      logic [7:0] echo_byte;
      logic [3:0] pins;
      logic       pwm_left;
      logic       pwm_right;
      logic [7:0] duty;
   } motor_status_type;

   motor_status_type predicted_status[$];

   // local copy of the core's settings and state
   scmp_pkg::cfg_type shadow_cfg = '{scmp_pkg::RST_PWM_PERIOD,
                                     scmp_pkg::RST_DUTY_DEFAULT,
                                     scmp_pkg::RST_DUTY_FULL,
                                     scmp_pkg::RST_DUTY_LIMIT};
   logic [3:0] pin_state   = scmp_pkg::PINS_STOP;
   logic [7:0] duty        = scmp_pkg::RST_DUTY_DEFAULT;
   logic [7:0] left_count  = '0;
   logic [7:0] right_count = '0;
   logic       left_level  = 1'b0;
   logic       right_level = 1'b0;

   int errors        = 0;
   int tx_idle_pct   = 0;
   int rx_idle_pct   = 0;
   int stall_request = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   function automatic logic [7:0] next_count(input logic [7:0] count);
      int n;
      n = count + 1;
      if (n >= shadow_cfg.pwm_period)
         n = 0;
      return n[7:0];
   endfunction

   function automatic void apply_motor_item(input logic [1:0] kind, input logic [7:0] rx);
      motor_status_type s;
      s = '0;
      case (kind)
         scmp_pkg::KIND_LEFT_TICK: begin
            left_count = next_count(left_count);
            left_level = (left_count <= duty);
         end
         scmp_pkg::KIND_RIGHT_TICK: begin
            right_count = next_count(right_count);
            right_level = (right_count <= duty);
         end
         scmp_pkg::KIND_RX_BYTE: begin
            s.echo_valid = 1'b1;
            s.echo_byte  = rx;
            case (rx)
               scmp_pkg::BYTE_STOP:    pin_state = scmp_pkg::PINS_STOP;
               scmp_pkg::BYTE_FORWARD: pin_state = scmp_pkg::PINS_FORWARD;
               scmp_pkg::BYTE_BACK:    pin_state = scmp_pkg::PINS_BACK;
               scmp_pkg::BYTE_LEFT:    pin_state = scmp_pkg::PINS_LEFT;
               scmp_pkg::BYTE_RIGHT:   pin_state = scmp_pkg::PINS_RIGHT;
               scmp_pkg::BYTE_SPEED_UP: begin
                  // limit is inclusive, so duty can land one above it
                  if (duty <= shadow_cfg.duty_limit && duty != scmp_pkg::DUTY_MAX)
                     duty = duty + 8'd1;
               end
               scmp_pkg::BYTE_SPEED_DOWN: begin
                  if (duty != 8'd0)
                     duty = duty - 8'd1;
               end
               scmp_pkg::BYTE_SPEED_DEF:  duty = shadow_cfg.duty_default;
               scmp_pkg::BYTE_SPEED_FULL: duty = shadow_cfg.duty_full;
               default: ;
            endcase
         end
         default: ;
      endcase
      s.pins      = pin_state;
      s.pwm_left  = left_level;
      s.pwm_right = right_level;
      s.duty      = duty;
      predicted_status.push_back(s);
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      motor_status_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (predicted_status.size() == 0) begin
            $error("rsp transfer with nothing predicted: tdata %h", rsp_tdata);
            errors++;
         end else begin
            want = predicted_status.pop_front();
            check_field("echo_valid", want.echo_valid, rsp_tuser[0]);
            check_field("echo_byte", want.echo_byte, rsp_tdata[7:0]);
            check_field("motor_pins", want.pins, rsp_tdata[11:8]);
            check_field("pwm_left", want.pwm_left, rsp_tdata[12]);
            check_field("pwm_right", want.pwm_right, rsp_tdata[13]);
            check_field("duty_now", want.duty, rsp_tdata[21:14]);
            check_field("tdata_pad", 0, rsp_tdata[23:22]);
         end
      end
   end

   // rsp ready: random idling, or a counted hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_request > 0) begin
            stall_left    = stall_request;
            stall_request = 0;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   task automatic set_idling(input int tx_pct, input int rx_pct);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
   endtask

   task automatic send_item(input logic [1:0] kind, input logic [7:0] rx);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= rx;
      do @(posedge clock); while (!req_tready);
      apply_motor_item(kind, rx);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (predicted_status.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic put_reg(input logic [1:0] index, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         scmp_pkg::CSR_PWM_PERIOD:   shadow_cfg.pwm_period   = value;
         scmp_pkg::CSR_DUTY_DEFAULT: shadow_cfg.duty_default = value;
         scmp_pkg::CSR_DUTY_FULL:    shadow_cfg.duty_full    = value;
         scmp_pkg::CSR_DUTY_LIMIT:   shadow_cfg.duty_limit   = value;
         default: ;
      endcase
   endtask

   // waits for the core to drain before writing the settings
   task automatic load_settings(input logic [7:0] period, input logic [7:0] dflt,
                                input logic [7:0] full, input logic [7:0] limit);
      wait_drained();
      put_reg(scmp_pkg::CSR_PWM_PERIOD, period);
      put_reg(scmp_pkg::CSR_DUTY_DEFAULT, dflt);
      put_reg(scmp_pkg::CSR_DUTY_FULL, full);
      put_reg(scmp_pkg::CSR_DUTY_LIMIT, limit);
      csr_valid <= 1'b0;
   endtask

   task automatic send_tick_run(input logic [1:0] kind, input int count);
      repeat (count) send_item(kind, 8'($urandom));
   endtask

   task automatic test_directed_commands();
      set_idling(9, 67);
      send_item(scmp_pkg::KIND_LEFT_TICK, 8'h00);
      send_item(scmp_pkg::KIND_RIGHT_TICK, 8'hFF);
      send_item(KIND_UNUSED, 8'hFF);
      send_item(KIND_UNUSED, 8'h00);
      send_item(scmp_pkg::KIND_RX_BYTE, scmp_pkg::BYTE_FORWARD);
      send_item(scmp_pkg::KIND_RX_BYTE, scmp_pkg::BYTE_BACK);
      send_item(scmp_pkg::KIND_RX_BYTE, scmp_pkg::BYTE_LEFT);
      send_item(scmp_pkg::KIND_RX_BYTE, scmp_pkg::BYTE_RIGHT);
      send_item(scmp_pkg::KIND_RX_BYTE, scmp_pkg::BYTE_STOP);
      send_item(scmp_pkg::KIND_RX_BYTE, scmp_pkg::BYTE_SPEED_UP);
      send_item(scmp_pkg::KIND_RX_BYTE, scmp_pkg::BYTE_SPEED_DOWN);
      send_item(scmp_pkg::KIND_RX_BYTE, scmp_pkg::BYTE_SPEED_FULL);
      send_item(scmp_pkg::KIND_LEFT_TICK, 8'h00);
      send_item(scmp_pkg::KIND_RX_BYTE, scmp_pkg::BYTE_SPEED_DEF);
      send_item(scmp_pkg::KIND_RIGHT_TICK, 8'h00);
      // bytes past the command range only echo
      send_item(scmp_pkg::KIND_RX_BYTE, 8'h09);
      send_item(scmp_pkg::KIND_RX_BYTE, 8'hFF);
      send_item(scmp_pkg::KIND_RX_BYTE, 8'h80);
   endtask

   task automatic test_duty_extremes();
      set_idling(9, 67);
      // raise stops at the top even with the widest limit
      load_settings(8'd2, 8'd0, 8'd255, 8'd255);
      send_item(scmp_pkg::KIND_RX_BYTE, scmp_pkg::BYTE_SPEED_FULL);
      send_item(scmp_pkg::KIND_RX_BYTE, scmp_pkg::BYTE_SPEED_UP);
      send_tick_run(scmp_pkg::KIND_LEFT_TICK, 3);
      // lower stops at zero
      send_item(scmp_pkg::KIND_RX_BYTE, scmp_pkg::BYTE_SPEED_DEF);
      send_item(scmp_pkg::KIND_RX_BYTE, scmp_pkg::BYTE_SPEED_DOWN);
      send_tick_run(scmp_pkg::KIND_RIGHT_TICK, 3);
      // degenerate periods keep the counters at zero
      load_settings(8'd1, 8'd0, 8'd255, 8'd254);
      send_tick_run(scmp_pkg::KIND_LEFT_TICK, 2);
      load_settings(8'd0, 8'd0, 8'd255, 8'd254);
      send_tick_run(scmp_pkg::KIND_RIGHT_TICK, 2);
   endtask

   task automatic test_period_shrink();
      set_idling(9, 67);
      load_settings(8'd255, 8'd5, 8'd20, 8'd20);
      send_tick_run(scmp_pkg::KIND_LEFT_TICK, 30);
      send_tick_run(scmp_pkg::KIND_RIGHT_TICK, 30);
      // counters now sit above the new period and must wrap on the next tick
      load_settings(8'd3, 8'd1, 8'd2, 8'd1);
      send_item(scmp_pkg::KIND_LEFT_TICK, 8'h00);
      send_item(scmp_pkg::KIND_RIGHT_TICK, 8'h00);
   endtask

   task automatic send_random_traffic(input int target);
      int sent;
      int pick;
      int run;
      sent = 0;
      while (sent < target) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            send_item(2'($urandom_range(1)), 8'($urandom));
            sent++;
         end else if (pick < 40) begin
            run = $urandom_range(2, 40);
            send_tick_run(2'($urandom_range(1)), run);
            sent += run;
         end else if (pick < 75) begin
            send_item(scmp_pkg::KIND_RX_BYTE,
                      8'($urandom_range(scmp_pkg::BYTE_STOP, scmp_pkg::BYTE_SPEED_FULL)));
            sent++;
         end else if (pick < 82) begin
            // climb or fall far enough to hit the duty limits
            run = $urandom_range(2, 30);
            repeat (run)
               send_item(scmp_pkg::KIND_RX_BYTE,
                         pick[0] ? scmp_pkg::BYTE_SPEED_UP : scmp_pkg::BYTE_SPEED_DOWN);
            sent += run;
         end else if (pick < 95) begin
            send_item(scmp_pkg::KIND_RX_BYTE, 8'($urandom));
            sent++;
         end else begin
            send_item(KIND_UNUSED, 8'($urandom));
            sent++;
         end
      end
   endtask

   task automatic test_random_settings();
      set_idling(9, 67);
      load_settings(scmp_pkg::RST_PWM_PERIOD, scmp_pkg::RST_DUTY_DEFAULT,
                    scmp_pkg::RST_DUTY_FULL, scmp_pkg::RST_DUTY_LIMIT);
      send_random_traffic(80);
      load_settings(8'd2, 8'd0, 8'd255, 8'd254);
      send_random_traffic(80);
      set_idling(67, 9);
      load_settings(8'd255, 8'd255, 8'd0, 8'd0);
      send_random_traffic(80);
      load_settings(8'($urandom_range(255)), 8'($urandom), 8'($urandom),
                    8'($urandom_range(254)));
      send_random_traffic(80);
      set_idling(0, 0);
      load_settings(8'd3, 8'd1, 8'd2, 8'd1);
      send_random_traffic(80);
      load_settings(8'($urandom_range(2, 255)), 8'($urandom), 8'($urandom),
                    8'($urandom_range(254)));
      send_random_traffic(80);
   endtask

   task automatic test_output_stall();
      set_idling(0, 0);
      stall_request = 60;
      send_random_traffic(30);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed_commands();
      test_duty_extremes();
      test_period_shrink();
      test_random_settings();
      test_output_stall();
      wait_drained();
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

/* filelist.f */
hdl/scmp_pkg.sv
hdl/scmp_csr.sv
hdl/scmp_cmd.sv
hdl/scmp_pwm.sv
hdl/serial_command_motor_pwm_core.sv
hdl/scmp_checker.sv
tb/tb_serial_command_motor_pwm_core.sv
